### sv/assert_macros.svh
// Assertion macros shared by the pressure/temperature compensation RTL.
// No dependencies; bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PTC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
`define PTC_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");
`else
`define PTC_ASSERT(lbl, clk, rst_n, prop)
`define PTC_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### sv/ptc_pkg.sv
// Shared types and constants for the pressure/temperature compensation block.
// No dependencies.
package ptc_pkg;

	localparam int RAW_W   = 20;
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);
	localparam int CIDX_W  = 2;
	localparam int CDATA_W = 64;

	// register indexes
	localparam logic [CIDX_W-1:0] CFG_TEMP   = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_PLOW   = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_PHIGH  = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_PNINE  = 2'd3;

	// one raw sample pair
	typedef struct packed {
		logic [RAW_W-1:0] raw_pressure;
		logic [RAW_W-1:0] raw_temperature;
	} item_t;

	// status of a multi-cycle arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

### sv/pressure_temperature_compensation.sv
// Each input beat is computed by 13 passes through one shared multiplier (a 64x64 unit
// built on one 32x32 multiplier), a radix-2 divider pass and three control states; a
// zero pressure divisor skips the divider and all steps after it. A new beat is taken
// from the queue only after the last result is in the output register; a two-entry input
// queue and that output register let both sides stall independently.
// Reset: arst_n clears control state and all calibration registers to 0.
module pressure_temperature_compensation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ptc_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [ptc_pkg::CDATA_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ptc_pkg::RAW_W-1:0]     raw_pressure,
	input  logic [ptc_pkg::RAW_W-1:0]     raw_temperature,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [23:0]            temperature_centi,
	output logic signed [31:0]            fine_temperature,
	output logic [31:0]                   pressure_pa_q8,
	output logic                          divide_error
);

	logic           q_valid;
	logic           q_pop;
	ptc_pkg::item_t q_item;

	ptc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.q_valid         (q_valid),
		.q_pop           (q_pop),
		.q_item          (q_item)
	);

	ptc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.q_valid           (q_valid),
		.q_pop             (q_pop),
		.q_item            (q_item),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.temperature_centi (temperature_centi),
		.fine_temperature  (fine_temperature),
		.pressure_pa_q8    (pressure_pa_q8),
		.divide_error      (divide_error)
	);

endmodule

### sv/ptc_front.sv
// Front end: accepts raw sample beats into a two-entry queue.
// Depends on ptc_pkg.
module ptc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [ptc_pkg::RAW_W-1:0] raw_pressure,
	input  logic [ptc_pkg::RAW_W-1:0] raw_temperature,
	output logic                  q_valid,
	input  logic                  q_pop,
	output ptc_pkg::item_t        q_item
);

	ptc_pkg::item_t                 mem_q [ptc_pkg::QDEPTH];
	logic [ptc_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [ptc_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [ptc_pkg::QCNT_W-1:0]     cnt_q;
	logic                           push;
	logic                           pop;

	assign in_ready = (cnt_q != ptc_pkg::QCNT_W'(ptc_pkg::QDEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{raw_pressure: raw_pressure, raw_temperature: raw_temperature};
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### sv/ptc_mul.sv
// Shared 64x64 wrapping multiplier built from one sequential 32x32 multiplier.
// Depends on ptc_pkg.
module ptc_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [63:0]         op_a,
	input  logic [63:0]         op_b,
	output ptc_pkg::unit_stat_t stat,
	output logic [63:0]         y
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_LL   = 3'd1;
	localparam logic [2:0] PH_LH   = 3'd2;
	localparam logic [2:0] PH_HL   = 3'd3;
	localparam logic [2:0] PH_ACC  = 3'd4;

	logic [2:0]  ph_q;
	logic        done_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] prod_s1;
	logic [63:0] acc_q;
	logic [31:0] mop_a;
	logic [31:0] mop_b;

	// partial product operand select
	assign mop_a = (ph_q == PH_HL) ? a_q[63:32] : a_q[31:0];
	assign mop_b = (ph_q == PH_LH) ? b_q[63:32] : b_q[31:0];

	assign stat.busy = (ph_q != PH_IDLE);
	assign stat.done = done_q;
	assign y         = acc_q;

	// operands, partial product and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= op_a;
			b_q <= op_b;
		end
		prod_s1 <= mop_a * mop_b;
		case (ph_q)
			PH_LH:   acc_q <= prod_s1;
			PH_HL:   acc_q <= acc_q + {prod_s1[31:0], 32'd0};
			PH_ACC:  acc_q <= acc_q + {prod_s1[31:0], 32'd0};
			default: acc_q <= acc_q;
		endcase
	end

	// phase sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= (ph_q == PH_ACC);
			unique case (ph_q)
				PH_IDLE: ph_q <= start ? PH_LL : PH_IDLE;
				PH_LL:   ph_q <= PH_LH;
				PH_LH:   ph_q <= PH_HL;
				PH_HL:   ph_q <= PH_ACC;
				PH_ACC:  ph_q <= PH_IDLE;
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

endmodule

### sv/ptc_div.sv
// Signed 64-bit divider, radix 2, one quotient bit per cycle, truncating.
// Depends on ptc_pkg.
module ptc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [63:0]         num,
	input  logic [63:0]         den,
	output ptc_pkg::unit_stat_t stat,
	output logic [63:0]         quo
);

	logic [6:0]  cnt_q;
	logic        done_q;
	logic        neg_q;
	logic [63:0] n_q;
	logic [63:0] d_q;
	logic [63:0] r_q;
	logic [64:0] rs;
	logic [64:0] diff;
	logic        qbit;

	// shift-subtract step
	assign rs   = {r_q, n_q[63]};
	assign diff = rs - {1'b0, d_q};
	assign qbit = !diff[64];

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign quo       = neg_q ? (64'd0 - n_q) : n_q;

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num[63] ? (64'd0 - num) : num;
			d_q   <= den[63] ? (64'd0 - den) : den;
			r_q   <= '0;
			neg_q <= num[63] ^ den[63];
		end else if (cnt_q != '0) begin
			r_q <= qbit ? diff[63:0] : rs[63:0];
			n_q <= {n_q[62:0], qbit};
		end
	end

	// iteration count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 7'd1);
			if (start)              cnt_q <= 7'd64;
			else if (cnt_q != '0)   cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

### sv/ptc_back.sv
// Back end: sequences the compensation formulas over the shared multiplier and
// divider and holds the result beat. Depends on ptc_pkg, ptc_mul, ptc_div, macros.
`include "assert_macros.svh"
module ptc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ptc_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [ptc_pkg::CDATA_W-1:0]   cfg_data,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  ptc_pkg::item_t                q_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [23:0]            temperature_centi,
	output logic signed [31:0]            fine_temperature,
	output logic [31:0]                   pressure_pa_q8,
	output logic                          divide_error
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_T0   = 5'd1;
	localparam logic [4:0] S_T1   = 5'd2;
	localparam logic [4:0] S_T2   = 5'd3;
	localparam logic [4:0] S_P0   = 5'd4;
	localparam logic [4:0] S_P1   = 5'd5;
	localparam logic [4:0] S_P2   = 5'd6;
	localparam logic [4:0] S_P3   = 5'd7;
	localparam logic [4:0] S_P4   = 5'd8;
	localparam logic [4:0] S_P5   = 5'd9;
	localparam logic [4:0] S_P6   = 5'd10;
	localparam logic [4:0] S_DIV  = 5'd11;
	localparam logic [4:0] S_P8   = 5'd12;
	localparam logic [4:0] S_P9   = 5'd13;
	localparam logic [4:0] S_P10  = 5'd14;
	localparam logic [4:0] S_FIN  = 5'd15;
	localparam logic [4:0] S_DONE = 5'd16;

	// calibration registers
	logic [47:0] tc_q;
	logic [63:0] pcl_q;
	logic [63:0] pch_q;
	logic [15:0] p9_q;

	logic [4:0]  state_q;
	logic        wait_q;
	logic [ptc_pkg::RAW_W-1:0] adc_p_q;
	logic [ptc_pkg::RAW_W-1:0] adc_t_q;

	// working registers
	logic signed [63:0] ta_q, dd_q, pa_q, aa_q, vb_q, u2_q, va_q, num_q, vp_q, m9_q;
	logic signed [63:0] ca_q, cb_q, res_q;
	logic signed [31:0] fine_q;
	logic signed [23:0] temp_q;
	logic               err_q;

	// output beat
	logic               out_valid_q;
	logic signed [23:0] temp_out_q;
	logic signed [31:0] fine_out_q;
	logic [31:0]        pres_out_q;
	logic               err_out_q;

	logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic signed [63:0] m, d2, fine64, t5, tt, num0, fin_u;
	logic [63:0]        mul_a, mul_b, mul_y, div_q;
	logic               mul_start, div_start, is_mul;
	ptc_pkg::unit_stat_t mul_st, div_st;

	// coefficient fields
	assign t1 = 64'(tc_q[15:0]);
	assign t2 = 64'($signed(tc_q[31:16]));
	assign t3 = 64'($signed(tc_q[47:32]));
	assign p1 = 64'(pcl_q[15:0]);
	assign p2 = 64'($signed(pcl_q[31:16]));
	assign p3 = 64'($signed(pcl_q[47:32]));
	assign p4 = 64'($signed(pcl_q[63:48]));
	assign p5 = 64'($signed(pch_q[15:0]));
	assign p6 = 64'($signed(pch_q[31:16]));
	assign p7 = 64'($signed(pch_q[47:32]));
	assign p8 = 64'($signed(pch_q[63:48]));
	assign p9 = 64'($signed(p9_q));

	assign m      = $signed(mul_y);
	assign d2     = vp_q >>> 13;
	assign fine64 = ta_q + (m >>> 14);
	assign t5     = (fine64 <<< 2) + fine64 + 64'sd128;
	assign tt     = t5 >>> 8;
	assign num0   = (64'(21'd1048576 - {1'b0, adc_p_q}) << 31) - vb_q;
	assign fin_u  = vp_q + ca_q + cb_q;

	// multiplier operand select per step
	always_comb begin
		is_mul = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			S_T0: begin
				mul_a = 64'(adc_t_q[19:3]) - (t1 << 1);
				mul_b = t2;
			end
			S_T1: begin
				mul_a = 64'(adc_t_q[19:4]) - t1;
				mul_b = 64'(adc_t_q[19:4]) - t1;
			end
			S_T2:  begin mul_a = dd_q;  mul_b = t3;           end
			S_P0:  begin mul_a = pa_q;  mul_b = pa_q;         end
			S_P1:  begin mul_a = aa_q;  mul_b = p6;           end
			S_P2:  begin mul_a = pa_q;  mul_b = p5;           end
			S_P3:  begin mul_a = aa_q;  mul_b = p3;           end
			S_P4:  begin mul_a = pa_q;  mul_b = p2;           end
			S_P5:  begin mul_a = u2_q;  mul_b = p1;           end
			S_P6:  begin mul_a = num0;  mul_b = 64'd3125;     end
			S_P8:  begin mul_a = p9;    mul_b = d2;           end
			S_P9:  begin mul_a = m9_q;  mul_b = d2;           end
			S_P10: begin mul_a = p8;    mul_b = vp_q;         end
			default: is_mul = 1'b0;
		endcase
	end

	assign mul_start = is_mul && !wait_q;
	assign div_start = (state_q == S_DIV) && !wait_q;
	assign q_pop     = (state_q == S_IDLE) && q_valid;

	ptc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.stat   (mul_st),
		.y      (mul_y)
	);

	ptc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (va_q),
		.stat   (div_st),
		.quo    (div_q)
	);

	// step results
	always_ff @(posedge clk) begin
		if (q_pop) begin
			adc_p_q <= q_item.raw_pressure;
			adc_t_q <= q_item.raw_temperature;
		end
		if (mul_st.done) begin
			case (state_q)
				S_T0: ta_q <= m >>> 11;
				S_T1: dd_q <= m >>> 12;
				S_T2: begin
					fine_q <= fine64[31:0];
					pa_q   <= fine64 - 64'sd128000;
					if (tt > 64'sd8388607)       temp_q <= 24'sh7FFFFF;
					else if (tt < -64'sd8388608) temp_q <= 24'sh800000;
					else                         temp_q <= tt[23:0];
				end
				S_P0:  aa_q <= m;
				S_P1:  vb_q <= m;
				S_P2:  vb_q <= vb_q + (m <<< 17) + (p4 <<< 35);
				S_P3:  u2_q <= m >>> 8;
				S_P4:  u2_q <= u2_q + (m <<< 12) + (64'sd1 <<< 47);
				S_P5: begin
					va_q  <= m >>> 33;
					err_q <= ((m >>> 33) == 64'sd0);
					res_q <= '0;
				end
				S_P6:  num_q <= m;
				S_P8:  m9_q  <= m;
				S_P9:  ca_q  <= m >>> 25;
				S_P10: cb_q  <= m >>> 19;
				default: ;
			endcase
		end
		if (div_st.done) vp_q <= $signed(div_q);
		if (state_q == S_FIN) res_q <= (fin_u >>> 8) + (p7 <<< 4);
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			temp_out_q <= temp_q;
			fine_out_q <= fine_q;
			pres_out_q <= res_q[31:0];
			err_out_q  <= err_q;
		end
	end

	// sequencer, calibration registers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wait_q      <= 1'b0;
			out_valid_q <= 1'b0;
			tc_q        <= '0;
			pcl_q       <= '0;
			pch_q       <= '0;
			p9_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ptc_pkg::CFG_TEMP:  tc_q  <= cfg_data[47:0];
					ptc_pkg::CFG_PLOW:  pcl_q <= cfg_data;
					ptc_pkg::CFG_PHIGH: pch_q <= cfg_data;
					ptc_pkg::CFG_PNINE: p9_q  <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (mul_start || div_start) wait_q <= 1'b1;
			unique case (state_q)
				S_IDLE: if (q_valid) state_q <= S_T0;
				S_T0, S_T1, S_T2, S_P0, S_P1, S_P2, S_P3, S_P4, S_P6, S_P8, S_P9: begin
					if (mul_st.done) begin
						wait_q  <= 1'b0;
						state_q <= state_q + 5'd1;
					end
				end
				S_P5: begin
					if (mul_st.done) begin
						wait_q  <= 1'b0;
						state_q <= ((m >>> 33) == 64'sd0) ? S_DONE : S_P6;
					end
				end
				S_DIV: begin
					if (div_st.done) begin
						wait_q  <= 1'b0;
						state_q <= S_P8;
					end
				end
				S_P10: begin
					if (mul_st.done) begin
						wait_q  <= 1'b0;
						state_q <= S_FIN;
					end
				end
				S_FIN: state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign temperature_centi = temp_out_q;
	assign fine_temperature  = fine_out_q;
	assign pressure_pa_q8    = pres_out_q;
	assign divide_error      = err_out_q;

	`PTC_NEVER(a_mul_overlap, clk, arst_n, mul_start && mul_st.busy)
	`PTC_NEVER(a_div_overlap, clk, arst_n, div_start && div_st.busy)
	`PTC_ASSERT(a_done_hold, clk, arst_n, (state_q == S_DONE && out_valid_q && !out_ready) |=> (state_q == S_DONE))
	`PTC_ASSERT(a_err_zero, clk, arst_n, (out_valid_q && err_out_q) |-> (pres_out_q == 32'd0))

endmodule
